// ----- src/mi3_pkg.sv -----
// Shared constants and index tables for the 3x3 matrix inverse block.
package mi3_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int INV_WIDTH  = 32;
    localparam int FIFO_DEPTH = 8;
    localparam int FRONT_LAT  = 4;

    // Cofactor k = m[a]*m[b] - m[c]*m[d], elements indexed row*3+col.
    localparam int CF_IDX [9][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    // Cofactors used to expand the determinant along row 0.
    localparam int DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic [FRONT_LAT-1:0] stage_vld;
    } t_front_stat;

endpackage

// ----- src/mi3_front.sv -----
// Front pipeline: cofactors and determinant of one matrix per cycle.
module mi3_front #(
    parameter int EW = mi3_pkg::ELEM_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [EW-1:0]    i_elem [9],
    output logic                    o_vld,
    output logic signed [2*EW:0]    o_cof [9],
    output logic signed [3*EW:0]    o_det,
    output mi3_pkg::t_front_stat    o_stat
);
    localparam int PW = 2 * EW;
    localparam int CW = 2 * EW + 1;
    localparam int DW = 3 * EW + 1;

    logic [mi3_pkg::FRONT_LAT-1:0] r_vld;
    logic signed [PW-1:0] r_pa [9];
    logic signed [PW-1:0] r_pb [9];
    logic signed [EW-1:0] r_row1 [3];
    logic signed [EW-1:0] r_row2 [3];
    logic signed [CW-1:0] r_cof2 [9];
    logic signed [CW-1:0] r_cof3 [9];
    logic signed [CW-1:0] r_cof4 [9];
    logic signed [DW-1:0] r_t [3];
    logic signed [DW-1:0] r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[mi3_pkg::FRONT_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_pa[k]   <= i_elem[mi3_pkg::CF_IDX[k][0]] * i_elem[mi3_pkg::CF_IDX[k][1]];
            r_pb[k]   <= i_elem[mi3_pkg::CF_IDX[k][2]] * i_elem[mi3_pkg::CF_IDX[k][3]];
            r_cof2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
            r_cof3[k] <= r_cof2[k];
            r_cof4[k] <= r_cof3[k];
        end
        for (int j = 0; j < 3; j++) begin
            r_row1[j] <= i_elem[j];
            r_row2[j] <= r_row1[j];
            r_t[j]    <= DW'(r_row2[j]) * DW'(r_cof2[mi3_pkg::DET_COF[j]]);
        end
        r_det <= DW'((DW+2)'(r_t[0]) + (DW+2)'(r_t[1]) + (DW+2)'(r_t[2]));
    end

    assign o_vld           = r_vld[mi3_pkg::FRONT_LAT-1];
    assign o_cof           = r_cof4;
    assign o_det           = r_det;
    assign o_stat.stage_vld = r_vld;

endmodule

// ----- src/mi3_queue.sv -----
// Small FIFO between the front pipeline and the divider.
module mi3_queue #(
    parameter int QW    = 8,
    parameter int DEPTH = mi3_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [QW-1:0]                i_data,
    input  logic                         i_pop,
    output logic                         o_vld,
    output logic [QW-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH+1);

    logic [QW-1:0]  r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CNW-1:0] r_cnt;
    logic           w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + AW'(1);
            if (w_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + CNW'(i_push) - CNW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_vld   = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

// ----- src/mi3_back.sv -----
// Back pipeline: nine restoring dividers, one quotient bit per stage, then saturation.
module mi3_back #(
    parameter int EW = mi3_pkg::ELEM_WIDTH,
    parameter int FB = mi3_pkg::FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [2*EW:0]                 i_cof [9],
    input  logic signed [3*EW:0]                 i_det,
    output logic                                 o_take,
    input  logic                                 i_pop,
    output logic                                 o_vld,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv [9],
    output logic signed [3*EW:0]                 o_det,
    output logic                                 o_sing
);
    localparam int CW = 2 * EW + 1;
    localparam int DW = 3 * EW + 1;
    localparam int QB = mi3_pkg::INV_WIDTH;
    localparam int XW = QB + DW;

    logic            r_v    [QB+1];
    logic [DW-1:0]   r_rem  [QB+1][9];
    logic [QB-1:0]   r_low  [QB+1][9];
    logic [QB-1:0]   r_quo  [QB+1][9];
    logic            r_neg  [QB+1][9];
    logic            r_ovf  [QB+1][9];
    logic [DW-1:0]   r_den  [QB+1];
    logic [DW-1:0]   r_detp [QB+1];
    logic            r_sing [QB+1];

    logic                 r_vo;
    logic signed [QB-1:0] r_inv [9];
    logic signed [DW-1:0] r_deto;
    logic                 r_singo;

    logic          w_adv;
    logic [DW-1:0] w_den;
    logic [CW-1:0] w_mag [9];
    logic [XW-1:0] w_num [9];

    // Whole pipe moves unless the output holds an untaken result.
    assign w_adv  = !r_vo || i_pop;
    assign o_take = w_adv && i_vld;

    always_comb begin
        w_den = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
        for (int k = 0; k < 9; k++) begin
            w_mag[k] = i_cof[k][CW-1] ? CW'(-i_cof[k]) : CW'(i_cof[k]);
            w_num[k] = XW'(w_mag[k]) << (2 * FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_vld;
            for (int s = 0; s < QB; s++) r_v[s+1] <= r_v[s];
            r_vo <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW:0] t;
        logic [QB-1:0] mag;
        if (w_adv) begin
            r_den[0]  <= w_den;
            r_detp[0] <= i_det;
            r_sing[0] <= (i_det == '0);
            for (int k = 0; k < 9; k++) begin
                r_rem[0][k] <= w_num[k][XW-1:QB];
                r_low[0][k] <= w_num[k][QB-1:0];
                r_quo[0][k] <= '0;
                r_neg[0][k] <= i_cof[k][CW-1] ^ i_det[DW-1];
                r_ovf[0][k] <= (w_num[k][XW-1:QB] >= w_den);
            end
            for (int s = 0; s < QB; s++) begin
                r_den[s+1]  <= r_den[s];
                r_detp[s+1] <= r_detp[s];
                r_sing[s+1] <= r_sing[s];
                for (int k = 0; k < 9; k++) begin
                    t = {r_rem[s][k], r_low[s][k][QB-1]};
                    if (t >= {1'b0, r_den[s]}) begin
                        r_rem[s+1][k] <= DW'(t - {1'b0, r_den[s]});
                        r_quo[s+1][k] <= {r_quo[s][k][QB-2:0], 1'b1};
                    end else begin
                        r_rem[s+1][k] <= DW'(t);
                        r_quo[s+1][k] <= {r_quo[s][k][QB-2:0], 1'b0};
                    end
                    r_low[s+1][k] <= {r_low[s][k][QB-2:0], 1'b0};
                    r_neg[s+1][k] <= r_neg[s][k];
                    r_ovf[s+1][k] <= r_ovf[s][k];
                end
            end
            // saturate and apply sign
            r_deto  <= r_sing[QB] ? '0 : r_detp[QB];
            r_singo <= r_sing[QB];
            for (int k = 0; k < 9; k++) begin
                if (r_sing[QB]) begin
                    r_inv[k] <= '0;
                end else if (r_neg[QB][k]) begin
                    mag = (r_ovf[QB][k] || r_quo[QB][k] > {1'b1, {(QB-1){1'b0}}})
                        ? {1'b1, {(QB-1){1'b0}}} : r_quo[QB][k];
                    r_inv[k] <= QB'(0) - mag;
                end else begin
                    r_inv[k] <= (r_ovf[QB][k] || r_quo[QB][k][QB-1])
                        ? {1'b0, {(QB-1){1'b1}}} : r_quo[QB][k];
                end
            end
        end
    end

    assign o_vld  = r_vo;
    assign o_inv  = r_inv;
    assign o_det  = r_deto;
    assign o_sing = r_singo;

endmodule

// ----- src/matrix_inverse_3x3.sv -----
// Top level of the 3x3 matrix inverse: front pipeline, queue, divider pipeline.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   input    | in        | i_push / o_full       | i_elem_00 .. i_elem_22 (Q3.12)
//   result   | out       | o_empty / i_pop       | o_inv_00 .. o_inv_22, o_determinant,
//            |           |                       | o_singular
//
// One request per cycle sustained while results are popped. A request passes the
// product/cofactor pipeline, the queue, then the divider (magnitude and range check,
// 32 stages of one quotient bit each, saturation register). The 32 quotient bits set
// the divider depth.
// Reset (synchronous, active low) empties every stage and the queue; no clearing pass.
// The divider stalls as a unit while a result waits unpopped; the front never stalls,
// so o_full counts requests in flight plus those queued against the queue depth.
module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_00,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_01,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_02,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_10,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_11,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_12,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_20,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_21,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem_22,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_00,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_01,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_02,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_10,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_11,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_12,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_20,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_21,
    output logic signed [mi3_pkg::INV_WIDTH-1:0] o_inv_22,
    output logic signed [3*ELEM_WIDTH:0]         o_determinant,
    output logic                                 o_singular
);
    localparam int CW    = 2 * ELEM_WIDTH + 1;
    localparam int DW    = 3 * ELEM_WIDTH + 1;
    localparam int QW    = 9 * CW + DW;
    localparam int DEPTH = mi3_pkg::FIFO_DEPTH;
    localparam int CNW   = $clog2(DEPTH + 1);

    logic signed [ELEM_WIDTH-1:0] w_elem [9];
    logic                         w_push;
    logic                         w_fvld;
    logic signed [CW-1:0]         w_fcof [9];
    logic signed [DW-1:0]         w_fdet;
    mi3_pkg::t_front_stat         w_fstat;
    logic [QW-1:0]                w_qin;
    logic [QW-1:0]                w_qout;
    logic                         w_qvld;
    logic [CNW-1:0]               w_qcnt;
    logic                         w_take;
    logic signed [CW-1:0]         w_bcof [9];
    logic signed [DW-1:0]         w_bdet;
    logic                         w_bvld;
    logic signed [mi3_pkg::INV_WIDTH-1:0] w_inv [9];
    logic [CNW:0]                 w_occ;

    assign w_elem = '{i_elem_00, i_elem_01, i_elem_02,
                      i_elem_10, i_elem_11, i_elem_12,
                      i_elem_20, i_elem_21, i_elem_22};

    // Every request in the front pipe already owns a queue slot.
    always_comb begin
        w_occ = (CNW+1)'(w_qcnt);
        for (int i = 0; i < mi3_pkg::FRONT_LAT; i++) begin
            w_occ = w_occ + (CNW+1)'(w_fstat.stage_vld[i]);
        end
    end

    assign o_full = (w_occ >= (CNW+1)'(DEPTH));
    assign w_push = i_push && !o_full;

    mi3_front #(.EW(ELEM_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_push),
        .i_elem  (w_elem),
        .o_vld   (w_fvld),
        .o_cof   (w_fcof),
        .o_det   (w_fdet),
        .o_stat  (w_fstat)
    );

    always_comb begin
        w_qin = '0;
        for (int k = 0; k < 9; k++) begin
            w_qin[k*CW +: CW] = w_fcof[k];
            w_bcof[k]         = w_qout[k*CW +: CW];
        end
        w_qin[9*CW +: DW] = w_fdet;
        w_bdet            = w_qout[9*CW +: DW];
    end

    mi3_queue #(.QW(QW), .DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fvld),
        .i_data  (w_qin),
        .i_pop   (w_take),
        .o_vld   (w_qvld),
        .o_data  (w_qout),
        .o_count (w_qcnt)
    );

    mi3_back #(.EW(ELEM_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_qvld),
        .i_cof   (w_bcof),
        .i_det   (w_bdet),
        .o_take  (w_take),
        .i_pop   (i_pop),
        .o_vld   (w_bvld),
        .o_inv   (w_inv),
        .o_det   (o_determinant),
        .o_sing  (o_singular)
    );

    assign o_empty  = !w_bvld;
    assign o_inv_00 = w_inv[0];
    assign o_inv_01 = w_inv[1];
    assign o_inv_02 = w_inv[2];
    assign o_inv_10 = w_inv[3];
    assign o_inv_11 = w_inv[4];
    assign o_inv_12 = w_inv[5];
    assign o_inv_20 = w_inv[6];
    assign o_inv_21 = w_inv[7];
    assign o_inv_22 = w_inv[8];

`ifndef SYNTHESIS
    a_queue_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= (CNW+1)'(DEPTH))
        else $error("queue over-committed");

    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_singular == (o_determinant == '0)))
        else $error("singular flag disagrees with determinant");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_singular) |-> (o_inv_00 == '0 && o_inv_11 == '0 && o_inv_22 == '0))
        else $error("singular request has nonzero inverse");
`endif

endmodule

// ----- tb/mi3_checker.sv -----
// Checker for the 3x3 matrix inverse: predicts each inverse and compares results.
`timescale 1ns / 1ps
module mi3_checker (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  logic                                       i_full,
    input  logic signed [mi3_pkg::ELEM_WIDTH-1:0]      i_elem [9],
    input  logic                                       i_empty,
    input  logic                                       i_pop,
    input  logic signed [mi3_pkg::INV_WIDTH-1:0]       i_inv [9],
    input  logic signed [3*mi3_pkg::ELEM_WIDTH:0]      i_det,
    input  logic                                       i_singular,
    output int                                         o_errors,
    output int                                         o_pending
);
    localparam int DETW = 3 * mi3_pkg::ELEM_WIDTH + 1;

    typedef struct {
        logic signed [mi3_pkg::INV_WIDTH-1:0]    inv [9];
        logic signed [DETW-1:0]                  det;
        logic                                    singular;
    } t_inverse;

    t_inverse inverse_q[$];

    function automatic logic signed [mi3_pkg::INV_WIDTH-1:0] quot_sat(longint cof,
                                                                     longint det);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        bit          neg;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0 ? -cof : cof);
        num = num << (2 * mi3_pkg::FRAC_BITS);
        den = (det < 0 ? -det : det);
        q   = num / den;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_inverse predict_inverse(
        logic signed [mi3_pkg::ELEM_WIDTH-1:0] e [9]);
        t_inverse r;
        longint   m [9];
        longint   cof [9];
        longint   d;
        // cofactor pairs: m[a]*m[b] - m[c]*m[d]
        int       ix [9][4] = '{'{4,8,5,7}, '{2,7,1,8}, '{1,5,2,4}, '{5,6,3,8},
                                '{0,8,2,6}, '{2,3,0,5}, '{3,7,4,6}, '{1,6,0,7},
                                '{0,4,1,3}};
        for (int k = 0; k < 9; k++) m[k] = longint'(e[k]);
        d = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
          - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
        for (int k = 0; k < 9; k++)
            cof[k] = m[ix[k][0]]*m[ix[k][1]] - m[ix[k][2]]*m[ix[k][3]];
        r.singular = (d == 0);
        r.det      = DETW'(d);
        for (int k = 0; k < 9; k++) r.inv[k] = (d == 0) ? '0 : quot_sat(cof[k], d);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_inverse want;
        int       n_err;
        n_err = 0;
        if (!i_rst_n) begin
            inverse_q.delete();
            o_errors <= 0;
        end else begin
            if (i_push && !i_full) inverse_q.push_back(predict_inverse(i_elem));
            if (i_pop && !i_empty) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: result with none expected: det %0d", $time, i_det);
                    n_err++;
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (i_inv[k] !== want.inv[k]) begin
                            $display("%0t: inv[%0d] expected %0d actual %0d",
                                     $time, k, want.inv[k], i_inv[k]);
                            n_err++;
                        end
                    if (i_det !== want.det || i_singular !== want.singular) begin
                        $display("%0t: det/singular expected %0d/%0b actual %0d/%0b",
                                 $time, want.det, want.singular, i_det, i_singular);
                        n_err++;
                    end
                end
            end
            o_errors <= o_errors + n_err;
        end
        o_pending <= inverse_q.size();
    end
endmodule

// ----- tb/tb_matrix_inverse_3x3.sv -----
// Testbench top for the 3x3 matrix inverse: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_matrix_inverse_3x3;

    localparam int EW         = mi3_pkg::ELEM_WIDTH;
    localparam int N_RANDOM   = 1030;
    localparam int STALL_MAX  = 2000; // cycles without any handshake

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    logic o_full, o_empty, o_singular;
    logic signed [EW-1:0] elem [9];
    logic signed [mi3_pkg::INV_WIDTH-1:0]  inv [9];
    logic signed [3*EW:0] o_determinant;
    int   errors, pending;
    int   idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    matrix_inverse_3x3 u_top (
        .i_clk, .i_rst_n, .i_push, .o_full,
        .i_elem_00(elem[0]), .i_elem_01(elem[1]), .i_elem_02(elem[2]),
        .i_elem_10(elem[3]), .i_elem_11(elem[4]), .i_elem_12(elem[5]),
        .i_elem_20(elem[6]), .i_elem_21(elem[7]), .i_elem_22(elem[8]),
        .o_empty, .i_pop,
        .o_inv_00(inv[0]), .o_inv_01(inv[1]), .o_inv_02(inv[2]),
        .o_inv_10(inv[3]), .o_inv_11(inv[4]), .o_inv_12(inv[5]),
        .o_inv_20(inv[6]), .o_inv_21(inv[7]), .o_inv_22(inv[8]),
        .o_determinant, .o_singular
    );

    mi3_checker u_checker (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_elem(elem),
        .i_empty(o_empty), .i_pop, .i_inv(inv), .i_det(o_determinant),
        .i_singular(o_singular), .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: any stretch this long without a handshake means the block hung.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("tb_matrix_inverse_3x3: errors");
            $finish;
        end
    end

    // Present one request, hold until accepted, then drop push for a random gap.
    // Push stays high across back-to-back requests when the gap is zero.
    task automatic send_matrix(logic signed [EW-1:0] m [9]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        for (int k = 0; k < 9; k++) elem[k] = m[k];
        i_push = 1'b1;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
        if (gap != 0) begin
            i_push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Random element: full range half the time, otherwise extremes, small values or one.
    function automatic logic signed [EW-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return EW'($urandom_range(0, 8) - 4);
            3:       return 16'sh1000;
            default: return EW'($urandom());
        endcase
    endfunction

    // Receiver: pop with random waits, including stretches with no waits.
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            wait_n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : 0;
            i_pop = 1'b0;
            repeat (wait_n) @(negedge i_clk);
            i_pop = 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    initial begin
        logic signed [EW-1:0] m [9];
        logic signed [EW-1:0] one;
        one = 16'sh1000;
        for (int k = 0; k < 9; k++) elem[k] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity
        m = '{one, 0, 0, 0, one, 0, 0, 0, one};
        send_matrix(m);
        // all zero: singular
        m = '{default: 0};
        send_matrix(m);
        // equal rows: singular despite nonzero content
        m = '{16'sh1234, -16'sh0567, 16'sh7FFF, 16'sh1234, -16'sh0567, 16'sh7FFF, 1, 2, 3};
        send_matrix(m);
        // all-min and all-max (singular)
        m = '{default: 16'sh8000};
        send_matrix(m);
        m = '{default: 16'sh7FFF};
        send_matrix(m);
        // diagonal extremes: largest determinant magnitudes
        m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(m);
        m = '{16'sh7FFF, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7FFF};
        send_matrix(m);
        // tiny determinant: large inverse, saturating positive and negative in the last case
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        m = '{1, 16'sh7FFF, 0, 0, 1, 16'sh8000, 0, 0, 1};
        send_matrix(m);
        // anti-diagonal, negative identity
        m = '{0, 0, one, 0, one, 0, one, 0, 0};
        send_matrix(m);
        m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};
        send_matrix(m);
        // all bits exercised
        m = '{16'shAAAA, 16'sh5555, 16'shFFFF, 16'sh0001, 16'shAAAA, 16'sh5555,
              16'sh5555, 16'sh0001, 16'shAAAA};
        send_matrix(m);

        for (int n = 0; n < N_RANDOM; n++) begin
            for (int k = 0; k < 9; k++) m[k] = rand_elem();
            // one in eight forced singular by copying a row
            if ($urandom_range(0, 7) == 0)
                for (int k = 0; k < 3; k++) m[6 + k] = m[k];
            send_matrix(m);
        end
        i_push = 1'b0;

        // drain, then allow for the divider depth
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("tb_matrix_inverse_3x3: clean");
        else
            $display("tb_matrix_inverse_3x3: errors");
        $finish;
    end
endmodule
